### src/vfb_pkg.sv
package vfb_pkg;

	localparam int RING_DEPTH_DEF  = 128;
	localparam int RETURN_BITS_DEF = 16;

	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [CFG_IDX_BITS-1:0] REG_WARMUP = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SHORT  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_LONG   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_LAMA   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_LAMB   = 3'd4;

	localparam int VAR_BITS   = 31;
	localparam int DAY_BITS   = 20;
	localparam int TOTAL_BITS = 51;
	localparam int WSUM_BITS  = 38;
	localparam int DIV_BITS   = 51;
	localparam int DEN_BITS   = 20;

	localparam logic [VAR_BITS-1:0] Q30_ONE = 31'h4000_0000;

	function automatic logic [VAR_BITS-1:0] clamp_q30(input logic [DIV_BITS-1:0] v);
		if (v > DIV_BITS'(Q30_ONE))
			return Q30_ONE;
		return v[VAR_BITS-1:0];
	endfunction

endpackage

### src/vfb_divider.sv
// Restoring divider, one quotient bit per cycle.
module vfb_divider
	import vfb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DIV_BITS-1:0] dividend,
	input  logic [DEN_BITS-1:0] divisor,
	output logic                done,
	output logic [DIV_BITS-1:0] quotient
);

	localparam int CNT_BITS = $clog2(DIV_BITS + 1);

	logic [DIV_BITS-1:0] quo_q;
	logic [DEN_BITS:0]   rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [DEN_BITS+1:0] trial;
	logic [DEN_BITS+1:0] shifted;

	assign shifted = {rem_q, quo_q[DIV_BITS-1]};
	assign trial   = shifted - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(DIV_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DEN_BITS+1]) begin
				rem_q <= trial[DEN_BITS:0];
				quo_q <= {quo_q[DIV_BITS-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DEN_BITS:0];
				quo_q <= {quo_q[DIV_BITS-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### src/vfb_ewma_mac.sv
// Bit-serial EWMA update: lam*s + (65536-lam)*r2, LSB of the weight first; shift the
// accumulator one bit per step.
module vfb_ewma_mac
	import vfb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [15:0]         lam,
	input  logic [VAR_BITS-1:0] s,
	input  logic [VAR_BITS-1:0] r2,
	output logic                done,
	output logic [VAR_BITS-1:0] result
);

	localparam int ACC_BITS = VAR_BITS + 18;

	logic [16:0]         wa_q, wb_q;
	logic [VAR_BITS-1:0] s_q, r_q;
	logic [ACC_BITS-1:0] acc_q;
	logic [4:0]          cnt_q;
	logic                busy_q, done_q;
	logic [ACC_BITS-1:0] addend;
	logic [ACC_BITS-1:0] sum;
	logic [ACC_BITS-1:0] fin;

	assign addend = (wa_q[0] ? ACC_BITS'(s_q) : '0) + (wb_q[0] ? ACC_BITS'(r_q) : '0);
	assign sum    = acc_q + (addend << 17);
	assign fin    = acc_q >> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd17;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			wa_q  <= {1'b0, lam};
			wb_q  <= 17'h10000 - {1'b0, lam};
			s_q   <= s;
			r_q   <= r2;
			acc_q <= '0;
		end else if (busy_q) begin
			wa_q  <= wa_q >> 1;
			wb_q  <= wb_q >> 1;
			acc_q <= sum >> 1;
		end
	end

	assign done   = done_q;
	assign result = (fin > ACC_BITS'(Q30_ONE)) ? Q30_ONE : fin[VAR_BITS-1:0];

endmodule

### src/variance_forecast_bank_unit.sv
// Each request that gives a result takes three divides on the shared bit-serial divider
// and then the two bit-serial EWMA MACs; the day that seeds the EWMAs takes one extra
// divide, and a muted warmup request gives no result. Requests are taken one at a time,
// and a result waits while the previous one is still held on the output.
// A window write while idle rebuilds its sum from the ring.
// Reset clears control, sums and EWMA state, then clears the ring.
module variance_forecast_bank_unit
	import vfb_pkg::*;
#(
	parameter int RING_DEPTH  = RING_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [RETURN_BITS_DEF-1:0] return_sample,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [DAY_BITS-1:0]          day_index,
	output logic [VAR_BITS-1:0]          realized_var,
	output logic [VAR_BITS-1:0]          roll_short_var,
	output logic [VAR_BITS-1:0]          roll_long_var,
	output logic [VAR_BITS-1:0]          ewma_a_var,
	output logic [VAR_BITS-1:0]          ewma_b_var,
	output logic [VAR_BITS-1:0]          expanding_var,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [CFG_DATA_BITS-1:0]     cfg_data
);

	localparam int PTR_BITS = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int WIN_BITS = $clog2(RING_DEPTH + 1);
	localparam int SQ_BITS  = 2 * RETURN_BITS_DEF;

	localparam logic [4:0] ST_CLEAR = 5'd0;
	localparam logic [4:0] ST_IDLE  = 5'd1;
	localparam logic [4:0] ST_RDS   = 5'd2;
	localparam logic [4:0] ST_RDSW  = 5'd3;
	localparam logic [4:0] ST_RDL   = 5'd4;
	localparam logic [4:0] ST_RDLW  = 5'd5;
	localparam logic [4:0] ST_SEED  = 5'd6;
	localparam logic [4:0] ST_DIV1  = 5'd7;
	localparam logic [4:0] ST_DIV2  = 5'd8;
	localparam logic [4:0] ST_DIV3  = 5'd9;
	localparam logic [4:0] ST_MAC   = 5'd10;
	localparam logic [4:0] ST_UPD   = 5'd11;
	localparam logic [4:0] ST_OUT   = 5'd12;
	localparam logic [4:0] ST_REB   = 5'd13;
	localparam logic [4:0] ST_REBW  = 5'd14;
	localparam logic [4:0] ST_DIV0  = 5'd15;
	localparam logic [4:0] ST_REBF  = 5'd16;

	logic [4:0] st_q;

	logic [15:0] warm_q, lama_q, lamb_q;
	logic [7:0]  sw_q, lw_q;

	logic [VAR_BITS-1:0] ring [RING_DEPTH];
	logic [VAR_BITS-1:0] rd_q;
	logic [PTR_BITS-1:0] ptr_q, clr_q;

	logic [WSUM_BITS-1:0]  ssum_q, lsum_q, rsum_q;
	logic [TOTAL_BITS-1:0] tsum_q;
	logic [VAR_BITS-1:0]   ea_q, eb_q, sq_q, olds_q, oldl_q;
	logic [DAY_BITS-1:0]   cnt_q;
	logic                  seeded_q, emit_q, reb_long_q;
	logic [WIN_BITS-1:0]   rcnt_q, rwin_q;

	logic [DAY_BITS-1:0] r_day_q;
	logic [VAR_BITS-1:0] r_rs_q, r_rl_q, r_ea_q, r_eb_q, r_ex_q;

	logic [DAY_BITS-1:0] o_day_q;
	logic [VAR_BITS-1:0] o_rs_q, o_rl_q, o_ea_q, o_eb_q, o_ex_q, o_sq_q;
	logic                ov_q;

	function automatic logic [PTR_BITS-1:0] ring_back(input logic [PTR_BITS-1:0] ptr,
		input logic [WIN_BITS-1:0] back);
		logic [31:0] v;
		v = 32'(ptr) + 32'(RING_DEPTH) - 32'(back);
		if (v >= 32'(RING_DEPTH))
			v = v - 32'(RING_DEPTH);
		return PTR_BITS'(v);
	endfunction

	// effective windows and warmup length
	logic [WIN_BITS-1:0] sw_eff, lw_eff;
	logic [15:0]         wu_eff;
	always_comb begin
		sw_eff = (sw_q == 8'd0) ? WIN_BITS'(1) :
			(32'(sw_q) > RING_DEPTH) ? WIN_BITS'(RING_DEPTH) : WIN_BITS'(sw_q);
		lw_eff = (lw_q == 8'd0) ? WIN_BITS'(1) :
			(32'(lw_q) > RING_DEPTH) ? WIN_BITS'(RING_DEPTH) : WIN_BITS'(lw_q);
		wu_eff = (warm_q == 16'd0) ? 16'd1 : warm_q;
	end

	// square of input
	logic [RETURN_BITS_DEF-1:0] mag;
	logic [SQ_BITS-1:0]     sq_full;
	assign mag     = return_sample[RETURN_BITS_DEF-1] ? RETURN_BITS_DEF'(-return_sample)
		: RETURN_BITS_DEF'(return_sample);
	assign sq_full = SQ_BITS'(mag) * SQ_BITS'(mag);

	// divider
	logic                div_start, div_done;
	logic [DIV_BITS-1:0] div_num, div_q;
	logic [DEN_BITS-1:0] div_den;
	vfb_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(div_den), .done(div_done), .quotient(div_q)
	);

	logic                mac_start, mac_done_a, mac_done_b;
	logic [VAR_BITS-1:0] mac_a, mac_b;
	vfb_ewma_mac u_maca (
		.clk(clk), .arst_n(arst_n), .start(mac_start), .lam(lama_q), .s(ea_q),
		.r2(sq_q), .done(mac_done_a), .result(mac_a)
	);
	vfb_ewma_mac u_macb (
		.clk(clk), .arst_n(arst_n), .start(mac_start), .lam(lamb_q), .s(eb_q),
		.r2(sq_q), .done(mac_done_b), .result(mac_b)
	);

	logic [PTR_BITS-1:0] rd_addr;
	logic [PTR_BITS-1:0] back_s, back_l, back_r;
	assign back_s = ring_back(ptr_q, sw_eff);
	assign back_l = ring_back(ptr_q, lw_eff);
	assign back_r = ring_back(ptr_q, rcnt_q);

	always_comb begin
		case (st_q)
			ST_RDS:  rd_addr = back_s;
			ST_RDL:  rd_addr = back_l;
			default: rd_addr = back_r;
		endcase
	end

	logic ring_we;
	logic [PTR_BITS-1:0] wr_addr;
	logic [VAR_BITS-1:0] wr_data;
	assign ring_we = (st_q == ST_CLEAR) || (st_q == ST_UPD);
	assign wr_addr = (st_q == ST_CLEAR) ? clr_q : ptr_q;
	assign wr_data = (st_q == ST_CLEAR) ? '0 : sq_q;

	always_ff @(posedge clk) begin
		if (ring_we)
			ring[wr_addr] <= wr_data;
		rd_q <= ring[rd_addr];
	end

	assign in_ready  = (st_q == ST_IDLE) && !cfg_we;
	assign div_start = (st_q == ST_SEED) || (st_q == ST_DIV0 && !emit_q)
		|| ((st_q == ST_DIV1 || st_q == ST_DIV2) && div_done);
	always_comb begin
		case (st_q)
			ST_DIV0: begin
				div_num = DIV_BITS'(ssum_q);
				div_den = DEN_BITS'(sw_eff);
			end
			ST_DIV1: begin
				div_num = DIV_BITS'(lsum_q);
				div_den = DEN_BITS'(lw_eff);
			end
			default: begin
				div_num = DIV_BITS'(tsum_q);
				div_den = cnt_q;
			end
		endcase
	end
	assign mac_start = (st_q == ST_DIV3) && div_done;

	logic [WSUM_BITS-1:0] ssum_n, lsum_n;
	assign ssum_n = ssum_q + WSUM_BITS'(sq_q) - WSUM_BITS'(olds_q);
	assign lsum_n = lsum_q + WSUM_BITS'(sq_q) - WSUM_BITS'(oldl_q);

	logic [TOTAL_BITS:0] tsum_add;
	assign tsum_add = {1'b0, tsum_q} + (TOTAL_BITS+1)'(sq_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_CLEAR;
			clr_q    <= '0;
			warm_q   <= 16'd66;
			sw_q     <= 8'd22;
			lw_q     <= 8'd66;
			lama_q   <= 16'd61604;
			lamb_q   <= 16'd63570;
			ptr_q    <= '0;
			ssum_q   <= '0;
			lsum_q   <= '0;
			tsum_q   <= '0;
			ea_q     <= '0;
			eb_q     <= '0;
			cnt_q    <= '0;
			seeded_q <= 1'b0;
			ov_q     <= 1'b0;
			emit_q   <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				ov_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_WARMUP: warm_q <= cfg_data;
					REG_SHORT:  sw_q   <= cfg_data[7:0];
					REG_LONG:   lw_q   <= cfg_data[7:0];
					REG_LAMA:   lama_q <= cfg_data;
					REG_LAMB:   lamb_q <= cfg_data;
					default: ;
				endcase
			end
			case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == RING_DEPTH - 1)
						st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cfg_we && (cfg_index == REG_SHORT || cfg_index == REG_LONG)) begin
						reb_long_q <= (cfg_index == REG_LONG);
						st_q       <= ST_REBF;
					end else if (in_valid && !cfg_we) begin
						sq_q   <= VAR_BITS'(sq_full);
						emit_q <= (cnt_q >= DAY_BITS'(wu_eff));
						st_q   <= ST_RDS;
					end
				end
				ST_REBF: begin
					// window register now holds the new value
					rwin_q <= reb_long_q ? lw_eff : sw_eff;
					rcnt_q <= WIN_BITS'(1);
					rsum_q <= '0;
					st_q   <= ST_REB;
				end
				ST_REB: st_q <= ST_REBW;
				ST_REBW: begin
					rsum_q <= rsum_q + WSUM_BITS'(rd_q);
					if (rcnt_q == rwin_q) begin
						if (reb_long_q)
							lsum_q <= rsum_q + WSUM_BITS'(rd_q);
						else
							ssum_q <= rsum_q + WSUM_BITS'(rd_q);
						st_q <= ST_IDLE;
					end else begin
						rcnt_q <= rcnt_q + 1'b1;
						st_q   <= ST_REB;
					end
				end
				ST_RDS: st_q <= ST_RDSW;
				ST_RDSW: begin
					olds_q <= rd_q;
					st_q   <= ST_RDL;
				end
				ST_RDL: st_q <= ST_RDLW;
				ST_RDLW: begin
					oldl_q <= rd_q;
					if (!emit_q)
						st_q <= ST_UPD;
					else if (!seeded_q)
						st_q <= ST_SEED;
					else
						st_q <= ST_DIV0;
				end
				ST_SEED: st_q <= ST_DIV0;
				ST_DIV0: begin
					if (!emit_q) begin
						st_q <= ST_DIV1;
					end else if (div_done) begin
						// seed quotient finished; clear emit_q so the short mean starts
						ea_q     <= clamp_q30(div_q);
						eb_q     <= clamp_q30(div_q);
						seeded_q <= 1'b1;
						emit_q   <= 1'b0;
					end else if (seeded_q) begin
						emit_q <= 1'b0;
					end
				end
				ST_DIV1: if (div_done) begin
					r_rs_q <= clamp_q30(div_q);
					st_q   <= ST_DIV2;
				end
				ST_DIV2: if (div_done) begin
					r_rl_q <= clamp_q30(div_q);
					st_q   <= ST_DIV3;
				end
				ST_DIV3: if (div_done) begin
					r_ex_q  <= clamp_q30(div_q);
					r_day_q <= cnt_q;
					r_ea_q  <= ea_q;
					r_eb_q  <= eb_q;
					st_q    <= ST_MAC;
				end
				ST_MAC: if (mac_done_a && mac_done_b) begin
					ea_q   <= mac_a;
					eb_q   <= mac_b;
					emit_q <= 1'b1;
					st_q   <= ST_UPD;
				end
				ST_UPD: begin
					ssum_q <= ssum_n;
					lsum_q <= lsum_n;
					ptr_q  <= (32'(ptr_q) == RING_DEPTH - 1) ? '0 : ptr_q + 1'b1;
					tsum_q <= tsum_add[TOTAL_BITS] ? '1 : tsum_add[TOTAL_BITS-1:0];
					if (cnt_q != '1)
						cnt_q <= cnt_q + 1'b1;
					st_q <= emit_q ? ST_OUT : ST_IDLE;
				end
				ST_OUT: begin
					// hold until the previous result has left
					if (!ov_q || out_ready) begin
						ov_q    <= 1'b1;
						o_day_q <= r_day_q;
						o_sq_q  <= sq_q;
						o_rs_q  <= r_rs_q;
						o_rl_q  <= r_rl_q;
						o_ea_q  <= r_ea_q;
						o_eb_q  <= r_eb_q;
						o_ex_q  <= r_ex_q;
						emit_q  <= 1'b0;
						st_q    <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = ov_q;
	assign day_index      = o_day_q;
	assign realized_var   = o_sq_q;
	assign roll_short_var = o_rs_q;
	assign roll_long_var  = o_rl_q;
	assign ewma_a_var     = o_ea_q;
	assign ewma_b_var     = o_eb_q;
	assign expanding_var  = o_ex_q;

endmodule

### tb/tb.sv
module tb
	import vfb_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING = RING_DEPTH_DEF;
	localparam int SETTLE = 400;
	localparam bit [63:0] DAY_MAX = (64'd1 << DAY_BITS) - 1;
	localparam bit [63:0] TOTAL_MAX = (64'd1 << TOTAL_BITS) - 1;

	typedef struct {
		bit [DAY_BITS-1:0] day;
		bit [VAR_BITS-1:0] realized, roll_short, roll_long, ewma_a, ewma_b, expanding;
	} forecast_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [RETURN_BITS_DEF-1:0] return_sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [DAY_BITS-1:0] day_index;
	logic [VAR_BITS-1:0] realized_var, roll_short_var, roll_long_var;
	logic [VAR_BITS-1:0] ewma_a_var, ewma_b_var, expanding_var;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	variance_forecast_bank_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .return_sample(return_sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.day_index(day_index), .realized_var(realized_var),
		.roll_short_var(roll_short_var), .roll_long_var(roll_long_var),
		.ewma_a_var(ewma_a_var), .ewma_b_var(ewma_b_var),
		.expanding_var(expanding_var),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	bit [63:0] warmup = 66, short_w = 22, long_w = 66, lam_a = 61604, lam_b = 63570;
	bit [63:0] sq_ring [RING];
	bit [63:0] short_sum, long_sum, total_sum, ewma_a, ewma_b, days;
	int ring_ptr;
	bit seeded;
	forecast_t forecast_q [$];

	int errors = 0;
	int returns_sent = 0;
	int forecasts_seen = 0;
	int hold_cycles = 0;
	bit rx_random = 1'b1;
	int rx_gap = 0;

	function automatic bit [63:0] eff_window(bit [63:0] w);
		if (w == 0)
			return 1;
		if (w > RING)
			return RING;
		return w;
	endfunction

	function automatic bit [63:0] clamp_one(bit [63:0] v);
		return (v > 64'(Q30_ONE)) ? 64'(Q30_ONE) : v;
	endfunction

	function automatic bit [63:0] ring_sum(bit [63:0] w);
		bit [63:0] s;
		s = 0;
		for (int k = 1; k <= w; k++)
			s += sq_ring[(ring_ptr + RING - k) % RING];
		return s;
	endfunction

	function automatic bit [63:0] ewma_step(bit [63:0] lam, bit [63:0] s, bit [63:0] r2);
		return clamp_one((lam * s + (64'd65536 - lam) * r2) >> 16);
	endfunction

	function automatic void apply_register(logic [CFG_IDX_BITS-1:0] idx, bit [15:0] v);
		case (idx)
			REG_WARMUP: warmup = 64'(v);
			REG_SHORT: begin
				short_w = 64'(v[7:0]);
				short_sum = ring_sum(eff_window(short_w));
			end
			REG_LONG: begin
				long_w = 64'(v[7:0]);
				long_sum = ring_sum(eff_window(long_w));
			end
			REG_LAMA: lam_a = 64'(v);
			REG_LAMB: lam_b = 64'(v);
			default: ;
		endcase
	endfunction

	function automatic void forecast_day(logic signed [RETURN_BITS_DEF-1:0] r);
		int v;
		bit [63:0] sq, sw, lw, wu, old;
		forecast_t f;
		v = r;
		sq = (v < 0) ? 64'(-v) * 64'(-v) : 64'(v) * 64'(v);
		sw = eff_window(short_w);
		lw = eff_window(long_w);
		wu = (warmup == 0) ? 1 : warmup;
		if (days >= wu) begin
			if (!seeded) begin
				ewma_a = clamp_one(total_sum / days);
				ewma_b = ewma_a;
				seeded = 1'b1;
			end
			f.day = days[DAY_BITS-1:0];
			f.realized = sq[VAR_BITS-1:0];
			f.roll_short = VAR_BITS'(clamp_one(short_sum / sw));
			f.roll_long = VAR_BITS'(clamp_one(long_sum / lw));
			f.ewma_a = ewma_a[VAR_BITS-1:0];
			f.ewma_b = ewma_b[VAR_BITS-1:0];
			f.expanding = VAR_BITS'(clamp_one(total_sum / days));
			forecast_q.push_back(f);
			ewma_a = ewma_step(lam_a, ewma_a, sq);
			ewma_b = ewma_step(lam_b, ewma_b, sq);
		end
		old = sq_ring[(ring_ptr + RING - sw) % RING];
		short_sum = short_sum + sq - old;
		old = sq_ring[(ring_ptr + RING - lw) % RING];
		long_sum = long_sum + sq - old;
		sq_ring[ring_ptr] = sq;
		ring_ptr = (ring_ptr + 1) % RING;
		total_sum = (TOTAL_MAX - total_sum < sq) ? TOTAL_MAX : total_sum + sq;
		if (days < DAY_MAX)
			days++;
	endfunction

	task automatic report(string field, bit [63:0] got, bit [63:0] want);
		errors++;
		$display("day %0d: %s got %0d expected %0d", forecasts_seen, field, got, want);
	endtask

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		forecast_t f;
		if (arst_n && out_valid && out_ready) begin
			if (forecast_q.size() == 0) begin
				report("unexpected result", day_index, 0);
			end else begin
				f = forecast_q.pop_front();
				if (day_index !== f.day) report("day_index", day_index, f.day);
				if (realized_var !== f.realized) report("realized_var", realized_var, f.realized);
				if (roll_short_var !== f.roll_short)
					report("roll_short_var", roll_short_var, f.roll_short);
				if (roll_long_var !== f.roll_long)
					report("roll_long_var", roll_long_var, f.roll_long);
				if (ewma_a_var !== f.ewma_a) report("ewma_a_var", ewma_a_var, f.ewma_a);
				if (ewma_b_var !== f.ewma_b) report("ewma_b_var", ewma_b_var, f.ewma_b);
				if (expanding_var !== f.expanding)
					report("expanding_var", expanding_var, f.expanding);
			end
			forecasts_seen++;
		end
	end

	// receiver: long hold-off on request, else always ready or short/rare long gaps
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else if (!rx_random) begin
			out_ready <= 1'b1;
		end else if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(3) == 0)
				rx_gap <= ($urandom_range(9) == 0) ? $urandom_range(80, 20) : $urandom_range(4, 1);
		end
	end

	task automatic send_return(logic signed [RETURN_BITS_DEF-1:0] r, bit gaps = 1'b1);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		return_sample <= r;
		do @(posedge clk); while (!in_ready);
		forecast_day(r);
		returns_sent++;
		gap = 0;
		if (gaps && $urandom_range(2) == 0)
			gap = ($urandom_range(9) == 0) ? $urandom_range(60, 10) : $urandom_range(3, 1);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (forecast_q.size() == 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_BITS-1:0] idx, bit [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		apply_register(idx, v);
		// let a window rebuild finish
		repeat (2 * RING) @(negedge clk);
	endtask

	function automatic logic signed [RETURN_BITS_DEF-1:0] random_return();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sd32767;
			2, 3: return $signed(16'($urandom_range(400))) - 16'sd200;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic run_returns(int n);
		repeat (n) send_return(random_return());
	endtask

	task automatic test_reset_settings();
		// seeding happens at the reset warmup length
		run_returns(80);
		drain();
	endtask

	task automatic test_extremes();
		write_register(REG_WARMUP, 16'd0);
		send_return(16'sd0);
		send_return(16'sh8000);
		send_return(16'sd32767);
		send_return(-16'sd32767);
		send_return(16'sd1);
		send_return(-16'sd1);
		send_return(16'sh5555);
		send_return(-16'sh5556);
		send_return(16'sd0, 1'b0);
		send_return(16'sh8000, 1'b0);
		send_return(16'sh8000, 1'b0);
		drain();
	endtask

	task automatic test_windows();
		bit [15:0] sizes [6] = '{16'd0, 16'd255, 16'd1, 16'd128, 16'd129, 16'd200};
		for (int i = 0; i < 6; i++) begin
			write_register(REG_SHORT, sizes[i]);
			write_register(REG_LONG, sizes[5 - i]);
			run_returns(25);
			drain();
		end
	endtask

	task automatic test_lambdas();
		write_register(REG_LAMA, 16'd0);
		write_register(REG_LAMB, 16'hFFFF);
		run_returns(20);
		drain();
		write_register(REG_LAMA, 16'hFFFF);
		write_register(REG_LAMB, 16'd0);
		run_returns(20);
		drain();
	endtask

	task automatic test_warmup_mute();
		// raise the warmup to mute, then lower it again; no second seeding
		write_register(REG_WARMUP, 16'hFFFF);
		run_returns(15);
		drain();
		write_register(REG_WARMUP, 16'd3);
		run_returns(15);
		drain();
	endtask

	task automatic test_backpressure();
		hold_cycles = 1500;
		repeat (6) send_return(random_return(), 1'b0);
		drain();
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 8; phase++) begin
			write_register(REG_WARMUP, 16'($urandom_range(40)));
			write_register(REG_SHORT, ($urandom_range(4) == 0) ? 16'd128 : 16'($urandom_range(255)));
			write_register(REG_LONG, ($urandom_range(4) == 0) ? 16'd1 : 16'($urandom_range(255)));
			write_register(REG_LAMA, ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom));
			write_register(REG_LAMB, ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom));
			rx_random = (phase % 3 != 2);
			run_returns(190);
			drain();
		end
		rx_random = 1'b1;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// wait out the ring clearing pass
		repeat (2 * RING) @(negedge clk);
		test_reset_settings();
		test_extremes();
		test_windows();
		test_lambdas();
		test_warmup_mute();
		test_backpressure();
		test_random();
		$display("Sent %0d returns and checked %0d forecasts", returns_sent, forecasts_seen);
		$display("Covered window, decay and warmup extremes, seeding and output stalls");
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#60ms;
		$display("Timed out with %0d forecasts pending", forecast_q.size());
		$display("Mismatches found");
		$finish;
	end
endmodule
